FILE: rtl/core/pixel_pair_error_metric_top_assert.svh
// Assertion macros for the pixel pair error metric block.
// Used by pixel_pair_error_metric_top; no other dependencies.
`ifndef PIXEL_PAIR_ERROR_METRIC_TOP_ASSERT_SVH
`define PIXEL_PAIR_ERROR_METRIC_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PPEM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked every cycle
`define PPEM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  `PPEM_ASSERT_IMPL(label, clk, rst_n, 1'b1, cond, msg)

`endif

FILE: rtl/core/ppem_pkg.sv
// Shared types and constants for the pixel pair error metric block.
// No dependencies.
package ppem_pkg;

  localparam int unsigned VALUE_BITS = 63;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SEL_BITS   = 3;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_BITS = 2;
  localparam int unsigned QCNT_BITS = 3;

  typedef logic [SEL_BITS-1:0] metric_sel_t;

  localparam metric_sel_t METRIC_MSE     = 3'd0;
  localparam metric_sel_t METRIC_RMSE    = 3'd1;
  localparam metric_sel_t METRIC_MAE     = 3'd2;
  localparam metric_sel_t METRIC_LINF    = 3'd3;
  localparam metric_sel_t METRIC_L0      = 3'd4;
  localparam metric_sel_t METRIC_L0_FRAC = 3'd5;
  localparam metric_sel_t METRIC_L1      = 3'd6;
  localparam metric_sel_t METRIC_L2      = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_e;

  typedef struct packed {
    logic       push;
    logic [1:0] lasts_in_flight;
  } front_stat_t;

  typedef struct packed {
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } q_stat_t;

endpackage

FILE: rtl/core/ppem_in_if.sv
// Input channel: one pixel pair per item, with last flag.
// No dependencies.
interface ppem_in_if #(
  parameter int unsigned PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_a;
  logic [PIXEL_BITS-1:0] pixel_b;
  logic                  last_pixel;

  modport source (output valid, pixel_a, pixel_b, last_pixel, input ready);
  modport sink   (input valid, pixel_a, pixel_b, last_pixel, output ready);
endinterface

FILE: rtl/core/ppem_out_if.sv
// Output channel: one metric result per item.
// Depends on ppem_pkg.
interface ppem_out_if #(
  parameter int unsigned MAX_COUNT_LOG2 = 24
);
  logic                            valid;
  logic                            ready;
  logic [ppem_pkg::VALUE_BITS-1:0] metric_value;
  logic [MAX_COUNT_LOG2:0]         pixel_count;
  logic                            count_overflow;

  modport source (output valid, metric_value, pixel_count, count_overflow, input ready);
  modport sink   (input valid, metric_value, pixel_count, count_overflow, output ready);
endinterface

FILE: rtl/core/ppem_front.sv
// Front end: abs difference, square, and per-image accumulation.
// Pushes an accumulator snapshot on each last pair. Depends on ppem_pkg, ppem_in_if.
module ppem_front #(
  parameter int unsigned PIXEL_BITS     = 16,
  parameter int unsigned MAX_COUNT_LOG2 = 24,
  parameter int unsigned SNAP_W         = 161
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppem_in_if.sink               pair_i,
  input  ppem_pkg::q_stat_t     q_stat_i,
  output ppem_pkg::front_stat_t stat_o,
  output logic [SNAP_W-1:0]     snap_o
);
  import ppem_pkg::*;

  localparam int unsigned CNTW    = MAX_COUNT_LOG2 + 1;
  localparam int unsigned AW      = PIXEL_BITS + MAX_COUNT_LOG2;
  localparam int unsigned SQ_FULL = 2 * PIXEL_BITS + MAX_COUNT_LOG2;
  localparam int unsigned SQW     = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int unsigned CRW     = QCNT_BITS + 1;

  logic                    accept;
  logic [PIXEL_BITS-1:0]   diff;
  logic [1:0]              lasts;
  logic [CRW-1:0]          credit_used;

  logic                    v1_q, l1_q, v2_q, l2_q;
  logic [PIXEL_BITS-1:0]   d1_q, d2_q;
  logic [2*PIXEL_BITS-1:0] sq2_q;

  logic [CNTW-1:0]         cnt_q, cnt_n, mis_q, mis_n;
  logic [AW-1:0]           abs_q, abs_n;
  logic [SQW-1:0]          sq_q, sq_n;
  logic [SQW:0]            sq_add;
  logic [PIXEL_BITS-1:0]   max_q, max_n;
  logic                    ovf_q, ovf_n;
  logic                    full;

  assign accept = pair_i.valid & pair_i.ready;
  assign diff   = (pair_i.pixel_a >= pair_i.pixel_b) ? pair_i.pixel_a - pair_i.pixel_b
                                                     : pair_i.pixel_b - pair_i.pixel_a;

  // every last pair in flight holds a queue slot
  assign lasts        = {1'b0, v1_q & l1_q} + {1'b0, v2_q & l2_q};
  assign credit_used  = CRW'(q_stat_i.count) + CRW'(lasts);
  assign pair_i.ready = (credit_used < CRW'(QDEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      l1_q <= 1'b0;
      v2_q <= 1'b0;
      l2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      l1_q <= accept & pair_i.last_pixel;
      v2_q <= v1_q;
      l2_q <= l1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q  <= diff;
    d2_q  <= d1_q;
    sq2_q <= d1_q * d1_q;
  end

  assign full   = cnt_q[CNTW-1];
  assign sq_add = {1'b0, sq_q} + (SQW+1)'(sq2_q);

  always_comb begin
    cnt_n = cnt_q;
    abs_n = abs_q;
    sq_n  = sq_q;
    max_n = max_q;
    mis_n = mis_q;
    ovf_n = ovf_q | full;
    if (!full) begin
      cnt_n = cnt_q + CNTW'(1);
      abs_n = abs_q + AW'(d2_q);
      sq_n  = sq_add[SQW] ? '1 : sq_add[SQW-1:0];
      if (d2_q > max_q) begin
        max_n = d2_q;
      end
      if (d2_q != '0) begin
        mis_n = mis_q + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      abs_q <= '0;
      sq_q  <= '0;
      max_q <= '0;
      mis_q <= '0;
      ovf_q <= 1'b0;
    end else if (v2_q) begin
      if (l2_q) begin
        cnt_q <= '0;
        abs_q <= '0;
        sq_q  <= '0;
        max_q <= '0;
        mis_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_n;
        abs_q <= abs_n;
        sq_q  <= sq_n;
        max_q <= max_n;
        mis_q <= mis_n;
        ovf_q <= ovf_n;
      end
    end
  end

  assign snap_o                 = {cnt_n, abs_n, sq_n, max_n, mis_n, ovf_n};
  assign stat_o.push            = v2_q & l2_q;
  assign stat_o.lasts_in_flight = lasts;

endmodule

FILE: rtl/core/ppem_queue.sv
// Short FIFO of per-image accumulator snapshots between front and back.
// Depends on ppem_pkg.
module ppem_queue #(
  parameter int unsigned WIDTH = 161
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  rdata_o,
  output ppem_pkg::q_stat_t stat_o
);
  import ppem_pkg::*;

  logic [WIDTH-1:0]     slot_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 do_pop;

  assign do_pop = pop_i & (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
      cnt_q <= cnt_q + QCNT_BITS'(push_i) - QCNT_BITS'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = slot_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

FILE: rtl/core/ppem_back.sv
// Back end: per-image metric engine with bit-serial divider and square root,
// plus the output register. Depends on ppem_pkg, ppem_out_if.
module ppem_back #(
  parameter int unsigned PIXEL_BITS     = 16,
  parameter int unsigned MAX_COUNT_LOG2 = 24,
  parameter int unsigned SNAP_W         = 161
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppem_pkg::metric_sel_t sel_i,
  input  ppem_pkg::q_stat_t     q_stat_i,
  input  logic [SNAP_W-1:0]     snap_i,
  output logic                  pop_o,
  ppem_out_if.source            result_o
);
  import ppem_pkg::*;

  localparam int unsigned CNTW    = MAX_COUNT_LOG2 + 1;
  localparam int unsigned AW      = PIXEL_BITS + MAX_COUNT_LOG2;
  localparam int unsigned SQ_FULL = 2 * PIXEL_BITS + MAX_COUNT_LOG2;
  localparam int unsigned SQW     = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int unsigned XW      = SQW + 32 + (SQW % 2);
  localparam int unsigned RW      = XW / 2;
  localparam int unsigned CW      = (XW > 64) ? XW : 64;
  localparam int unsigned STW     = $clog2(XW + 1);

  logic [CNTW-1:0]       s_cnt, s_mis;
  logic [AW-1:0]         s_abs;
  logic [SQW-1:0]        s_sq;
  logic [PIXEL_BITS-1:0] s_max;
  logic                  s_ovf;

  back_state_e       state_q, state_d;
  logic [XW-1:0]     x_q, x_d;
  logic [CNTW-1:0]   n_q, n_d, rem_q, rem_d;
  logic [RW-1:0]     root_q, root_d;
  logic [RW+1:0]     srem_q, srem_d;
  logic [STW-1:0]    step_q, step_d;
  logic              sqrt_q, sqrt_d;
  logic [CNTW-1:0]   rcnt_q, rcnt_d;
  logic              rovf_q, rovf_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic [CNTW-1:0]       out_cnt_q, out_cnt_d;
  logic                  out_ovf_q, out_ovf_d;

  logic [CNTW:0]   rem_sh;
  logic            div_ge;
  logic [RW+3:0]   srem_sh, trial;
  logic            sqrt_ge;
  logic [CW-1:0]   x_ext;
  logic            sat;

  assign {s_cnt, s_abs, s_sq, s_max, s_mis, s_ovf} = snap_i;

  // restoring divide step
  assign rem_sh = {rem_q, x_q[XW-1]};
  assign div_ge = (rem_sh >= {1'b0, n_q});

  // digit-by-digit root step
  assign srem_sh = {srem_q, x_q[XW-1:XW-2]};
  assign trial   = (RW+4)'({root_q, 2'b01});
  assign sqrt_ge = (srem_sh >= trial);

  assign x_ext = CW'(x_q);
  assign sat   = |x_ext[CW-1:VALUE_BITS];

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    n_d         = n_q;
    rem_d       = rem_q;
    root_d      = root_q;
    srem_d      = srem_q;
    step_d      = step_q;
    sqrt_d      = sqrt_q;
    rcnt_d      = rcnt_q;
    rovf_d      = rovf_q;
    out_valid_d = out_valid_q & ~result_o.ready;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;
    pop_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          n_d    = s_cnt;
          rcnt_d = s_cnt;
          rovf_d = s_ovf;
          rem_d  = '0;
          root_d = '0;
          srem_d = '0;
          step_d = STW'(XW);
          sqrt_d = 1'b0;
          case (sel_i)
            METRIC_MSE: begin
              x_d     = XW'(s_sq) << FRAC_BITS;
              state_d = ST_DIV;
            end
            METRIC_RMSE: begin
              x_d     = XW'(s_sq) << (2 * FRAC_BITS);
              sqrt_d  = 1'b1;
              state_d = ST_DIV;
            end
            METRIC_MAE: begin
              x_d     = XW'(s_abs) << FRAC_BITS;
              state_d = ST_DIV;
            end
            METRIC_LINF: begin
              x_d     = XW'(s_max) << FRAC_BITS;
              state_d = ST_DONE;
            end
            METRIC_L0: begin
              x_d     = XW'(s_mis) << FRAC_BITS;
              state_d = ST_DONE;
            end
            METRIC_L0_FRAC: begin
              x_d     = XW'(s_mis) << FRAC_BITS;
              state_d = ST_DIV;
            end
            METRIC_L1: begin
              x_d     = XW'(s_abs) << FRAC_BITS;
              state_d = ST_DONE;
            end
            default: begin
              x_d     = XW'(s_sq) << (2 * FRAC_BITS);
              step_d  = STW'(RW);
              state_d = ST_SQRT;
            end
          endcase
          // an empty count gives a zero mean
          if (state_d == ST_DIV && s_cnt == '0) begin
            x_d     = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? CNTW'(rem_sh - {1'b0, n_q}) : CNTW'(rem_sh);
        x_d    = {x_q[XW-2:0], div_ge};
        step_d = step_q - STW'(1);
        if (step_q == STW'(1)) begin
          if (sqrt_q) begin
            step_d  = STW'(RW);
            state_d = ST_SQRT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SQRT: begin
        srem_d = sqrt_ge ? (RW+2)'(srem_sh - trial) : (RW+2)'(srem_sh);
        root_d = {root_q[RW-2:0], sqrt_ge};
        x_d    = x_q << 2;
        step_d = step_q - STW'(1);
        if (step_q == STW'(1)) begin
          x_d     = XW'(root_d);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = sat ? '1 : x_ext[VALUE_BITS-1:0];
          out_cnt_d   = rcnt_q;
          out_ovf_d   = rovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    n_q       <= n_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    srem_q    <= srem_d;
    step_q    <= step_d;
    sqrt_q    <= sqrt_d;
    rcnt_q    <= rcnt_d;
    rovf_q    <= rovf_d;
    out_val_q <= out_val_d;
    out_cnt_q <= out_cnt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.metric_value   = out_val_q;
  assign result_o.pixel_count    = out_cnt_q;
  assign result_o.count_overflow = out_ovf_q;

endmodule

FILE: rtl/core/pixel_pair_error_metric_top.sv
// Pixel pair error metric, top level. Accepts one pixel pair per cycle, no bubbles
// while the snapshot queue (4 images deep) has room; a last pair is queued once it has
// passed the front's difference and square registers. MSE, MAE and L0 fraction use the
// divider, L2 the square root, RMSE the divider and then the root, the rest neither.
// The engine value is XW bits: square-sum width + 32, rounded up to even (88 at defaults).
// rst_ni (async, active low) clears accumulators, queue, engine and metric select.
`include "pixel_pair_error_metric_top_assert.svh"

module pixel_pair_error_metric_top #(
  parameter int unsigned PIXEL_BITS     = 16,
  parameter int unsigned MAX_COUNT_LOG2 = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  ppem_pkg::metric_sel_t cfg_wdata_i,
  ppem_in_if.sink               pair_i,
  ppem_out_if.source            result_o
);
  import ppem_pkg::*;

  localparam int unsigned CNTW    = MAX_COUNT_LOG2 + 1;
  localparam int unsigned AW      = PIXEL_BITS + MAX_COUNT_LOG2;
  localparam int unsigned SQ_FULL = 2 * PIXEL_BITS + MAX_COUNT_LOG2;
  localparam int unsigned SQW     = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int unsigned SNAP_W  = 2 * CNTW + AW + SQW + PIXEL_BITS + 1;

  metric_sel_t       sel_q;
  front_stat_t       f_stat;
  q_stat_t           q_stat;
  logic [SNAP_W-1:0] snap_in, snap_out;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= METRIC_MSE;
    end else if (cfg_we_i) begin
      sel_q <= cfg_wdata_i;
    end
  end

  ppem_front #(
    .PIXEL_BITS     (PIXEL_BITS),
    .MAX_COUNT_LOG2 (MAX_COUNT_LOG2),
    .SNAP_W         (SNAP_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair_i),
    .q_stat_i (q_stat),
    .stat_o   (f_stat),
    .snap_o   (snap_in)
  );

  ppem_queue #(
    .WIDTH (SNAP_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_stat.push),
    .wdata_i (snap_in),
    .pop_i   (pop),
    .rdata_o (snap_out),
    .stat_o  (q_stat)
  );

  ppem_back #(
    .PIXEL_BITS     (PIXEL_BITS),
    .MAX_COUNT_LOG2 (MAX_COUNT_LOG2),
    .SNAP_W         (SNAP_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sel_i    (sel_q),
    .q_stat_i (q_stat),
    .snap_i   (snap_out),
    .pop_o    (pop),
    .result_o (result_o)
  );

  `PPEM_ASSERT_ALWAYS(a_queue_credit, clk_i, rst_ni, ({1'b0, q_stat.count} + {2'b00, f_stat.lasts_in_flight}) <= 4'(QDEPTH), "queue credit exceeded")
  `PPEM_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, !q_stat.empty, "pop from empty queue")
  `PPEM_ASSERT_IMPL(a_ovf_count_full, clk_i, rst_ni, result_o.valid && result_o.count_overflow, result_o.pixel_count[MAX_COUNT_LOG2], "overflow without full count")

endmodule
